// File: rtl/pfsp_pkg.sv
`timescale 1ns / 1ps

package pfsp_pkg;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 88;
  localparam int FIELD_W    = 31;
  localparam int STAR_W     = 32;

  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_H      = 8'h68;
  localparam logic [7:0] CHAR_L_LOW  = 8'h6C;
  localparam logic [7:0] CHAR_L_UP   = 8'h4C;

  localparam int FB_HASH  = 0;
  localparam int FB_MINUS = 1;
  localparam int FB_PLUS  = 2;
  localparam int FB_ZERO  = 3;
  localparam int FB_SPACE = 4;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_H    = 3'd1;
  localparam logic [2:0] LEN_HH   = 3'd2;
  localparam logic [2:0] LEN_L    = 3'd3;
  localparam logic [2:0] LEN_LL   = 3'd4;
  localparam logic [2:0] LEN_BIG_L = 3'd5;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_ARG  = 1'b1;

  // Only phases that survive a step are stored; the others are passed
  // through inside the decode of a single character.
  typedef enum logic [3:0] {
    PH_FLAGS,
    PH_WWAIT,
    PH_WAFTER,
    PH_WDIGITS,
    PH_PSTART,
    PH_PWAIT,
    PH_PDIGITS,
    PH_LEN,
    PH_HSEEN,
    PH_LSEEN,
    PH_END
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [4:0] flags;
    logic       dot_seen;
    logic [2:0] length_code;
    logic [7:0] used_count;
  } ctl_t;

  typedef struct packed {
    logic               status;
    logic               alt_form;
    logic               left_align;
    logic               force_sign;
    logic               zero_pad;
    logic               space_sign;
    logic [FIELD_W-1:0] field_width;
    logic               has_precision;
    logic [FIELD_W-1:0] precision_value;
    logic [2:0]         length_mod;
    logic [7:0]         end_char;
    logic [7:0]         chars_used;
  } res_t;

endpackage

// File: rtl/pfsp_step.sv
`timescale 1ns / 1ps

module pfsp_step #(
  parameter int VALUE_BITS = 31
) (
  input  pfsp_pkg::ctl_t                ctl,
  input  logic [VALUE_BITS-1:0]         width_acc,
  input  logic [VALUE_BITS-1:0]         prec_acc,
  input  logic                          mode,
  input  logic [7:0]                    char_in,
  input  logic [pfsp_pkg::STAR_W-1:0]   star_value,
  output pfsp_pkg::ctl_t                ctl_nxt,
  output logic [VALUE_BITS-1:0]         width_nxt,
  output logic [VALUE_BITS-1:0]         prec_nxt,
  output logic                          emit,
  output pfsp_pkg::res_t                res
);
  import pfsp_pkg::*;

  localparam logic [VALUE_BITS-1:0] VMAX = {VALUE_BITS{1'b1}};

  function automatic logic [VALUE_BITS-1:0] acc_digit(input logic [VALUE_BITS-1:0] acc,
                                                      input logic [3:0] d);
    logic [VALUE_BITS+3:0] sum;
    sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{VALUE_BITS{1'b0}}, d};
    if (|sum[VALUE_BITS+3:VALUE_BITS]) return VMAX;
    return sum[VALUE_BITS-1:0];
  endfunction

  logic is_flag, is_star, is_digit, is_dot, is_h, is_l, is_big_l;
  logic reach_wstart, reach_wafter, in_width, reach_pdot, reach_len;
  logic w_digit, p_digit, err_hit, end_hit;
  logic star_neg;
  logic [STAR_W-1:0] star_mag;
  logic [VALUE_BITS-1:0] star_sat;
  logic [VALUE_BITS-1:0] width_base;
  logic left, plus;

  assign is_flag  = (char_in == CHAR_HASH) || (char_in == CHAR_MINUS) ||
                    (char_in == CHAR_PLUS) || (char_in == CHAR_ZERO) ||
                    (char_in == CHAR_SPACE);
  assign is_star  = (char_in == CHAR_STAR);
  assign is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
  assign is_dot   = (char_in == CHAR_DOT);
  assign is_h     = (char_in == CHAR_H);
  assign is_l     = (char_in == CHAR_L_LOW);
  assign is_big_l = (char_in == CHAR_L_UP);

  // A character that does not fit the current phase falls through to the
  // later phases within the same step.
  assign reach_wstart = (ctl.phase == PH_FLAGS) && !is_flag;
  assign reach_wafter = (ctl.phase == PH_WAFTER) || (reach_wstart && !is_star);
  assign in_width     = reach_wafter || (ctl.phase == PH_WDIGITS);
  assign w_digit      = in_width && is_digit;
  assign reach_pdot   = in_width && !is_digit;
  assign p_digit      = ((ctl.phase == PH_PSTART) || (ctl.phase == PH_PDIGITS)) && is_digit;
  assign reach_len    = (ctl.phase == PH_LEN) || (reach_pdot && !is_dot) ||
                        ((ctl.phase == PH_PSTART) && !is_star && !is_digit) ||
                        ((ctl.phase == PH_PDIGITS) && !is_digit);
  assign err_hit      = (ctl.phase == PH_WWAIT) || (ctl.phase == PH_PWAIT);
  assign end_hit      = (ctl.phase == PH_END) ||
                        (reach_len && !is_h && !is_l && !is_big_l) ||
                        ((ctl.phase == PH_HSEEN) && !is_h) ||
                        ((ctl.phase == PH_LSEEN) && !is_l);

  // Digits after a star width start again from zero.
  assign width_base = (ctl.phase == PH_WDIGITS) ? width_acc : '0;

  assign star_neg = star_value[STAR_W-1];
  assign star_mag = star_neg ? (~star_value + 1'b1) : star_value;
  assign star_sat = (|star_mag[STAR_W-1:VALUE_BITS]) ? VMAX : star_mag[VALUE_BITS-1:0];

  assign left = ctl.flags[FB_MINUS];
  assign plus = ctl.flags[FB_PLUS];

  always_comb begin
    ctl_nxt   = ctl;
    width_nxt = width_acc;
    prec_nxt  = prec_acc;
    emit      = 1'b0;
    res       = '0;
    if (mode == MODE_ARG) begin
      if (ctl.phase == PH_WWAIT) begin
        if (star_neg) ctl_nxt.flags[FB_MINUS] = 1'b1;
        width_nxt     = star_sat;
        ctl_nxt.phase = PH_WAFTER;
      end else if (ctl.phase == PH_PWAIT) begin
        if (star_neg) begin
          ctl_nxt.dot_seen = 1'b0;
          prec_nxt         = '0;
        end else begin
          prec_nxt = star_sat;
        end
        ctl_nxt.phase = PH_LEN;
      end
    end else if (err_hit) begin
      emit           = 1'b1;
      res.status     = STATUS_ERR;
      res.end_char   = char_in;
      res.chars_used = ctl.used_count;
      ctl_nxt        = '{phase: PH_FLAGS, default: '0};
      width_nxt      = '0;
      prec_nxt       = '0;
    end else if (end_hit) begin
      emit                = 1'b1;
      res.status          = STATUS_OK;
      res.alt_form        = ctl.flags[FB_HASH];
      res.left_align      = left;
      res.force_sign      = plus;
      res.zero_pad        = ctl.flags[FB_ZERO] && !left;
      res.space_sign      = ctl.flags[FB_SPACE] && !plus;
      res.field_width     = FIELD_W'(width_acc);
      res.has_precision   = ctl.dot_seen;
      res.precision_value = ctl.dot_seen ? FIELD_W'(prec_acc) : '0;
      res.length_mod      = ctl.length_code;
      res.end_char        = char_in;
      res.chars_used      = ctl.used_count;
      ctl_nxt             = '{phase: PH_FLAGS, default: '0};
      width_nxt           = '0;
      prec_nxt            = '0;
    end else begin
      // Every remaining path consumes the character.
      if (ctl.used_count != 8'hFF) ctl_nxt.used_count = ctl.used_count + 8'd1;
      if ((ctl.phase == PH_FLAGS) && is_flag) begin
        if (char_in == CHAR_HASH)  ctl_nxt.flags[FB_HASH]  = 1'b1;
        if (char_in == CHAR_MINUS) ctl_nxt.flags[FB_MINUS] = 1'b1;
        if (char_in == CHAR_PLUS)  ctl_nxt.flags[FB_PLUS]  = 1'b1;
        if (char_in == CHAR_ZERO)  ctl_nxt.flags[FB_ZERO]  = 1'b1;
        if (char_in == CHAR_SPACE) ctl_nxt.flags[FB_SPACE] = 1'b1;
      end else if (reach_wstart && is_star) begin
        ctl_nxt.phase = PH_WWAIT;
      end else if (w_digit) begin
        width_nxt     = acc_digit(width_base, char_in[3:0]);
        ctl_nxt.phase = PH_WDIGITS;
      end else if (reach_pdot && is_dot) begin
        ctl_nxt.dot_seen = 1'b1;
        prec_nxt         = '0;
        ctl_nxt.phase    = PH_PSTART;
      end else if ((ctl.phase == PH_PSTART) && is_star) begin
        ctl_nxt.phase = PH_PWAIT;
      end else if (p_digit) begin
        prec_nxt      = acc_digit(prec_acc, char_in[3:0]);
        ctl_nxt.phase = PH_PDIGITS;
      end else if (reach_len) begin
        if (is_h) begin
          ctl_nxt.length_code = LEN_H;
          ctl_nxt.phase       = PH_HSEEN;
        end else if (is_l) begin
          ctl_nxt.length_code = LEN_L;
          ctl_nxt.phase       = PH_LSEEN;
        end else begin
          ctl_nxt.length_code = LEN_BIG_L;
          ctl_nxt.phase       = PH_END;
        end
      end else if (ctl.phase == PH_HSEEN) begin
        ctl_nxt.length_code = LEN_HH;
        ctl_nxt.phase       = PH_END;
      end else begin
        ctl_nxt.length_code = LEN_LL;
        ctl_nxt.phase       = PH_END;
      end
    end
  end

endmodule

// File: rtl/pfsp_out_reg.sv
`timescale 1ns / 1ps

module pfsp_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  pfsp_pkg::res_t res_in,
  input  logic           take,
  output logic           valid,
  output pfsp_pkg::res_t res_out
);
  import pfsp_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) valid_nxt = 1'b1;
    else if (take) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign valid   = valid_r;
  assign res_out = res_r;

endmodule

// File: rtl/printf_spec_parser.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake         | Payload
// in_     | request   | tvalid / tready   | tuser = mode, tdata = char_in, star_value
// out_    | result    | tvalid / tready   | tuser = status, tdata = all spec fields
//
// One request is taken every cycle while the result register is empty or being
// drained; a finished spec appears on out_ in the cycle after its ending character.
// Each character is decoded in a single pass from the phase register and the
// two value accumulators, so the rate is one request per clock.
// Reset clears the phase, flags, counts and the result valid bit.
// A stalled result holds in_tready low until it is taken.

module printf_spec_parser #(
  parameter int VALUE_BITS = 31
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic                              in_tuser,   // [0] mode
  input  logic [pfsp_pkg::IN_DATA_W-1:0]    in_tdata,   // [7:0] char_in, [39:8] star_value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic                              out_tuser,  // [0] status
  // [0] alt_form, [1] left_align, [2] force_sign, [3] zero_pad, [4] space_sign,
  // [35:5] field_width, [36] has_precision, [67:37] precision_value,
  // [70:68] length_mod, [78:71] end_char, [86:79] chars_used, [87] zero
  output logic [pfsp_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import pfsp_pkg::*;

  ctl_t ctl_r, ctl_nxt;
  logic [VALUE_BITS-1:0] width_r, width_nxt;
  logic [VALUE_BITS-1:0] prec_r, prec_nxt;
  logic accept, emit;
  res_t res, res_q;

  assign in_tready = !out_tvalid || out_tready;
  assign accept    = in_tvalid && in_tready;

  pfsp_step #(
    .VALUE_BITS(VALUE_BITS)
  ) u_step (
    .ctl        (ctl_r),
    .width_acc  (width_r),
    .prec_acc   (prec_r),
    .mode       (in_tuser),
    .char_in    (in_tdata[7:0]),
    .star_value (in_tdata[39:8]),
    .ctl_nxt    (ctl_nxt),
    .width_nxt  (width_nxt),
    .prec_nxt   (prec_nxt),
    .emit       (emit),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r   <= '{phase: PH_FLAGS, default: '0};
      width_r <= '0;
      prec_r  <= '0;
    end else if (accept) begin
      ctl_r   <= ctl_nxt;
      width_r <= width_nxt;
      prec_r  <= prec_nxt;
    end
  end

  pfsp_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (accept && emit),
    .res_in  (res),
    .take    (out_tready),
    .valid   (out_tvalid),
    .res_out (res_q)
  );

  assign out_tuser = res_q.status;
  assign out_tdata = {1'b0, res_q.chars_used, res_q.end_char, res_q.length_mod,
                      res_q.precision_value, res_q.has_precision, res_q.field_width,
                      res_q.space_sign, res_q.zero_pad, res_q.force_sign,
                      res_q.left_align, res_q.alt_form};

endmodule

// File: rtl/pfsp_checker.sv
`timescale 1ns / 1ps

module pfsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic        out_tuser,
  input logic [87:0] out_tdata
);

  // The input side is open exactly when the result register can take a result.
  a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow the result register");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // An argument value never completes a spec.
  a_arg_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser && !out_tvalid |=> !out_tvalid)
    else $error("argument request produced a result");

  a_error_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[70:0] == 71'd0)
    else $error("error result carries spec fields");

  a_flag_overrides: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> !(out_tdata[3] && out_tdata[1]) &&
                                 !(out_tdata[4] && out_tdata[2]) &&
                                 out_tdata[70:68] <= 3'd5)
    else $error("flag override or length code broken");

endmodule

bind printf_spec_parser pfsp_checker u_pfsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);

// File: tb/printf_spec_parser_tb.sv
`timescale 1ns / 1ps

module printf_spec_parser_tb;
  import pfsp_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_REQS  = 75;
  localparam logic [FIELD_W-1:0] VALUE_MAX = '1;

  // Every step of the scan, including the two that never outlive one character.
  typedef enum logic [3:0] {
    SC_FLAGS, SC_WSTART, SC_WWAIT, SC_WAFTER, SC_WDIGITS, SC_PDOT, SC_PSTART,
    SC_PWAIT, SC_PDIGITS, SC_LEN, SC_HSEEN, SC_LSEEN, SC_END
  } scan_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic                  in_tuser   = MODE_CHAR;   // [0] mode
  logic [IN_DATA_W-1:0]  in_tdata   = '0;          // [7:0] char_in, [39:8] star_value
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  out_tuser;                // [0] status
  logic [OUT_DATA_W-1:0] out_tdata;                // spec fields, alt_form at bit 0

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int req_count      = 0;
  int result_count   = 0;
  int arg_err_count  = 0;
  int error_count    = 0;
  int quiet_cycles   = 0;

  // Predicted parser state.
  scan_t              spec_phase;
  logic [4:0]         spec_flags;
  logic [FIELD_W-1:0] spec_width;
  logic [FIELD_W-1:0] spec_prec;
  logic               spec_dot;
  logic [2:0]         spec_len;
  logic [7:0]         spec_used;

  res_t pending_specs[$];

  printf_spec_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void spec_clear();
    spec_phase = SC_FLAGS;
    spec_flags = '0;
    spec_width = '0;
    spec_prec  = '0;
    spec_dot   = 1'b0;
    spec_len   = LEN_NONE;
    spec_used  = '0;
  endfunction

  function automatic void bump_used();
    if (spec_used != 8'hFF) spec_used = spec_used + 8'd1;
  endfunction

  function automatic bit is_dec(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [FIELD_W-1:0] dec_step(input logic [FIELD_W-1:0] acc,
                                                  input logic [7:0] c);
    logic [63:0] sum;
    sum = 64'(acc) * 64'd10 + 64'(c - CHAR_ZERO);
    return (sum > 64'(VALUE_MAX)) ? VALUE_MAX : sum[FIELD_W-1:0];
  endfunction

  task automatic spec_take_char(input logic [7:0] c);
    bit   done;
    res_t r;
    done = 1'b0;
    while (!done) begin
      case (spec_phase)
        SC_FLAGS: begin
          done = 1'b1;
          if (c == CHAR_HASH) spec_flags[FB_HASH] = 1'b1;
          else if (c == CHAR_MINUS) spec_flags[FB_MINUS] = 1'b1;
          else if (c == CHAR_PLUS) spec_flags[FB_PLUS] = 1'b1;
          else if (c == CHAR_ZERO) spec_flags[FB_ZERO] = 1'b1;
          else if (c == CHAR_SPACE) spec_flags[FB_SPACE] = 1'b1;
          else begin
            done = 1'b0;
            spec_phase = SC_WSTART;
          end
          if (done) bump_used();
        end
        SC_WSTART: begin
          if (c == CHAR_STAR) begin
            bump_used();
            spec_phase = SC_WWAIT;
            done = 1'b1;
          end else spec_phase = SC_WAFTER;
        end
        SC_WAFTER: begin
          // Digits after a star width replace its value.
          if (is_dec(c)) begin
            spec_width = '0;
            spec_phase = SC_WDIGITS;
          end else spec_phase = SC_PDOT;
        end
        SC_WDIGITS: begin
          if (is_dec(c)) begin
            spec_width = dec_step(spec_width, c);
            bump_used();
            done = 1'b1;
          end else spec_phase = SC_PDOT;
        end
        SC_PDOT: begin
          if (c == CHAR_DOT) begin
            spec_dot   = 1'b1;
            spec_prec  = '0;
            bump_used();
            spec_phase = SC_PSTART;
            done = 1'b1;
          end else spec_phase = SC_LEN;
        end
        SC_PSTART: begin
          if (c == CHAR_STAR) begin
            bump_used();
            spec_phase = SC_PWAIT;
            done = 1'b1;
          end else spec_phase = is_dec(c) ? SC_PDIGITS : SC_LEN;
        end
        SC_PDIGITS: begin
          if (is_dec(c)) begin
            spec_prec = dec_step(spec_prec, c);
            bump_used();
            done = 1'b1;
          end else spec_phase = SC_LEN;
        end
        SC_LEN: begin
          if (c == CHAR_H) begin
            bump_used();
            spec_len = LEN_H;
            spec_phase = SC_HSEEN;
            done = 1'b1;
          end else if (c == CHAR_L_LOW) begin
            bump_used();
            spec_len = LEN_L;
            spec_phase = SC_LSEEN;
            done = 1'b1;
          end else if (c == CHAR_L_UP) begin
            bump_used();
            spec_len = LEN_BIG_L;
            spec_phase = SC_END;
            done = 1'b1;
          end else spec_phase = SC_END;
        end
        SC_HSEEN: begin
          if (c == CHAR_H) begin
            bump_used();
            spec_len = LEN_HH;
            done = 1'b1;
          end
          spec_phase = SC_END;
        end
        SC_LSEEN: begin
          if (c == CHAR_L_LOW) begin
            bump_used();
            spec_len = LEN_LL;
            done = 1'b1;
          end
          spec_phase = SC_END;
        end
        SC_WWAIT, SC_PWAIT: begin
          r = '0;
          r.status     = STATUS_ERR;
          r.end_char   = c;
          r.chars_used = spec_used;
          pending_specs.push_back(r);
          spec_clear();
          done = 1'b1;
        end
        default: begin
          r.status          = STATUS_OK;
          r.alt_form        = spec_flags[FB_HASH];
          r.left_align      = spec_flags[FB_MINUS];
          r.force_sign      = spec_flags[FB_PLUS];
          r.zero_pad        = spec_flags[FB_ZERO] & ~spec_flags[FB_MINUS];
          r.space_sign      = spec_flags[FB_SPACE] & ~spec_flags[FB_PLUS];
          r.field_width     = spec_width;
          r.has_precision   = spec_dot;
          r.precision_value = spec_dot ? spec_prec : '0;
          r.length_mod      = spec_len;
          r.end_char        = c;
          r.chars_used      = spec_used;
          pending_specs.push_back(r);
          spec_clear();
          done = 1'b1;
        end
      endcase
    end
  endtask

  task automatic spec_take_arg(input logic [STAR_W-1:0] v);
    logic [STAR_W:0]    mag;
    logic [FIELD_W-1:0] clipped;
    mag = v[STAR_W-1] ? ({1'b1, {STAR_W{1'b0}}} - {1'b0, v}) : {1'b0, v};
    clipped = (mag > {2'b00, VALUE_MAX}) ? VALUE_MAX : mag[FIELD_W-1:0];
    if (spec_phase == SC_WWAIT) begin
      if (v[STAR_W-1]) spec_flags[FB_MINUS] = 1'b1;
      spec_width = clipped;
      spec_phase = SC_WAFTER;
    end else if (spec_phase == SC_PWAIT) begin
      // A negative star precision behaves as if no precision were given.
      if (v[STAR_W-1]) begin
        spec_dot  = 1'b0;
        spec_prec = '0;
      end else spec_prec = clipped;
      spec_phase = SC_LEN;
    end
  endtask

  // in_tvalid stays high across back-to-back requests and is only lowered
  // when a gap is inserted.
  task automatic send_item(input logic mode, input logic [7:0] c, input logic [STAR_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {v, c};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (mode == MODE_ARG) begin
      if (spec_phase == SC_WWAIT || spec_phase == SC_PWAIT) req_count++;
      spec_take_arg(v);
    end else begin
      req_count++;
      spec_take_char(c);
    end
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(MODE_CHAR, c, $urandom);
  endtask

  task automatic send_arg(input logic [STAR_W-1:0] v);
    send_item(MODE_ARG, 8'($urandom_range(255)), v);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_digits(input int n);
    for (int i = 0; i < n; i++) send_char(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
  endtask

  function automatic logic [7:0] pick_flag();
    case ($urandom_range(4))
      0:       return CHAR_HASH;
      1:       return CHAR_ZERO;
      2:       return CHAR_MINUS;
      3:       return CHAR_PLUS;
      default: return CHAR_SPACE;
    endcase
  endfunction

  function automatic logic [STAR_W-1:0] pick_star();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'd0 - $urandom_range(1, 60);
      5:       return $urandom_range(1, 60);
      default: return $urandom;
    endcase
  endfunction

  // A star followed either by its argument or, now and then, by a stray
  // character that should produce an argument error.
  task automatic send_star_arg();
    send_char(CHAR_STAR);
    if ($urandom_range(11) == 0) send_char(8'($urandom_range(255)));
    else send_arg(pick_star());
  endtask

  task automatic send_random_spec();
    string conv;
    int    n;
    conv = "diouxXeEfFgGaAcspn%";
    case ($urandom_range(19))
      0: send_arg($urandom);
      1: send_char(8'($urandom_range(255)));
      default: ;
    endcase
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) send_char(pick_flag());
    case ($urandom_range(4))
      1, 4: send_digits(($urandom_range(9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 3));
      2: send_star_arg();
      3: begin
        send_star_arg();
        send_digits($urandom_range(1, 3));
      end
      default: ;
    endcase
    case ($urandom_range(3))
      1: send_char(CHAR_DOT);
      2: begin
        send_char(CHAR_DOT);
        send_digits(($urandom_range(9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 3));
      end
      3: begin
        send_char(CHAR_DOT);
        send_star_arg();
      end
      default: ;
    endcase
    case ($urandom_range(5))
      1: send_char(CHAR_H);
      2: send_text("hh");
      3: send_char(CHAR_L_LOW);
      4: send_text("ll");
      5: send_char(CHAR_L_UP);
      default: ;
    endcase
    if ($urandom_range(3) == 0) send_char(8'($urandom_range(255)));
    else send_char(conv[$urandom_range(conv.len() - 1)]);
  endtask

  task automatic test_flags();
    send_text("#0-+ d");
    send_text("0 x");
    send_text("-0+ #i");
  endtask

  task automatic test_width();
    send_text("2147483647d");
    send_text("99999999999u");
    send_text("0*");
    send_arg(32'd0 - 32'd7);
    send_text("x");
    send_char(CHAR_STAR);
    send_arg(32'h8000_0000);
    send_text("12s");
    send_char(CHAR_STAR);
    send_arg(32'h7FFF_FFFF);
    send_text("c");
  endtask

  task automatic test_precision();
    send_text(".f");
    send_text(".2147483648e");
    send_text(".*");
    send_arg(32'h7FFF_FFFF);
    send_text("g");
    send_text(".*");
    send_arg(32'hFFFF_FFFF);
    send_text("5");
    send_text(".*");
    send_arg('0);
    send_text("hd");
  endtask

  task automatic test_length();
    send_text("hd");
    send_text("hhd");
    send_text("ld");
    send_text("lld");
    send_text("Lf");
    send_text("Lh");
    send_text("hhh");
  endtask

  task automatic test_arg_errors();
    send_text("*q");
    send_text("5.**");
    send_arg(32'hFFFF_FFFF);
    send_text("-");
    send_arg(32'h1234_5678);
    send_text("d");
  endtask

  task automatic test_char_extremes();
    send_char(8'h00);
    send_char(8'hFF);
    send_text("#");
    send_char(8'hFF);
  endtask

  task automatic test_long_spec();
    for (int i = 0; i < 300; i++) send_char(CHAR_HASH);
    send_text("d");
  endtask

  task automatic test_random(input int idle_pct, input int stall_pct);
    int start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = req_count;
    while (req_count - start < PHASE_REQS) send_random_spec();
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $time, result_count, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status          = out_tuser;
      got.alt_form        = out_tdata[0];
      got.left_align      = out_tdata[1];
      got.force_sign      = out_tdata[2];
      got.zero_pad        = out_tdata[3];
      got.space_sign      = out_tdata[4];
      got.field_width     = out_tdata[35:5];
      got.has_precision   = out_tdata[36];
      got.precision_value = out_tdata[67:37];
      got.length_mod      = out_tdata[70:68];
      got.end_char        = out_tdata[78:71];
      got.chars_used      = out_tdata[86:79];
      if (pending_specs.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        want = pending_specs.pop_front();
        if (want.status == STATUS_ERR) arg_err_count++;
        check_field("status", 32'(got.status), 32'(want.status));
        check_field("alt_form", 32'(got.alt_form), 32'(want.alt_form));
        check_field("left_align", 32'(got.left_align), 32'(want.left_align));
        check_field("force_sign", 32'(got.force_sign), 32'(want.force_sign));
        check_field("zero_pad", 32'(got.zero_pad), 32'(want.zero_pad));
        check_field("space_sign", 32'(got.space_sign), 32'(want.space_sign));
        check_field("field_width", 32'(got.field_width), 32'(want.field_width));
        check_field("has_precision", 32'(got.has_precision), 32'(want.has_precision));
        check_field("precision_value", 32'(got.precision_value),
                    32'(want.precision_value));
        check_field("length_mod", 32'(got.length_mod), 32'(want.length_mod));
        check_field("end_char", 32'(got.end_char), 32'(want.end_char));
        check_field("chars_used", 32'(got.chars_used), 32'(want.chars_used));
        check_field("padding", 32'(out_tdata[87]), 32'd0);
      end
      result_count++;
    end
  end

  // Any stretch without a single handshake on either side means the block hung.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    spec_clear();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_flags();
    test_width();
    test_precision();
    test_length();
    test_arg_errors();
    test_char_extremes();
    test_long_spec();
    test_random(0, 0);
    test_random(79, 0);
    test_random(0, 79);
    test_random(12, 12);
    in_tvalid <= 1'b0;
    while (pending_specs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Parsed %0d requests into %0d specs, %0d of them argument errors,",
             req_count, result_count, arg_err_count);
    $display("covering flags, star and digit widths, precisions, length modifiers and stalls.");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
